// File: rtl/btc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// btc_pkg
// shared widths, constants, register indexes and control structs for the
// binomial trial counter
// ============================================================================
package btc_pkg;

    localparam int unsigned SEED_W     = 31;
    localparam int unsigned CNT_W      = 11;
    localparam int unsigned MULT_W     = 15;
    localparam int unsigned PROD_W     = SEED_W + MULT_W;
    localparam int unsigned ADDR_W     = 4;
    localparam int unsigned DATA_W     = 32;

    localparam int unsigned MAX_TRIALS_DEF = 1024;

    // minimal standard generator constants
    localparam logic [MULT_W-1:0] LCG_MULT     = 15'd16807;
    localparam logic [SEED_W-1:0] LCG_MODULUS  = 31'h7fff_ffff;
    localparam logic [SEED_W-1:0] DEFAULT_SEED = 31'd10259;

    localparam logic [SEED_W-1:0] THRESHOLD_RST = 31'd1073741823;

    // register indexes, byte address is 4 * index
    localparam logic [1:0] REG_TRIAL_COUNT = 2'd0;
    localparam logic [1:0] REG_THRESHOLD   = 2'd1;
    localparam logic [1:0] REG_START_SEED  = 2'd2;

    typedef struct packed {
        logic start;     // load trial counter, clear success count
        logic step;      // advance the generator one trial
        logic load_out;  // capture count and seed into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic done;      // no trials left in this draw
    } t_dp_sts;

endpackage

`default_nettype wire

// File: rtl/btc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// btc_datapath
// seed register, modular multiply step, trial and success counters, and the
// output word register
// ============================================================================
module btc_datapath
    import btc_pkg::*;
#(
    parameter int unsigned MAX_TRIALS = MAX_TRIALS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  wire                i_seed_wr,
    input  wire [SEED_W-1:0]   i_seed_value,
    input  wire [CNT_W-1:0]    i_trial_count,
    input  wire [SEED_W-1:0]   i_threshold,
    output logic [CNT_W-1:0]   o_success_count,
    output logic [SEED_W-1:0]  o_final_seed
);

    localparam int unsigned TW    = $clog2(MAX_TRIALS + 1);
    localparam int unsigned CMP_W = (TW > CNT_W) ? TW : CNT_W;
    localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_TRIALS);

    logic [SEED_W-1:0] r_seed, n_seed;
    logic [TW-1:0]     r_remain, n_remain;
    logic [TW-1:0]     r_count, n_count;
    logic              r_hit_pend, n_hit_pend;

    logic [CMP_W-1:0]  w_tc_ext;
    logic [TW-1:0]     w_trials;
    logic [SEED_W-1:0] w_seed_in;
    logic [PROD_W-1:0] w_prod;
    logic [SEED_W:0]   w_fold;
    logic [SEED_W-1:0] w_seed_next;
    logic              w_step_fire;

    // saturate requested trials at the build limit
    assign w_tc_ext = CMP_W'(i_trial_count);
    assign w_trials = (w_tc_ext > MAX_EXT) ? TW'(MAX_EXT) : TW'(w_tc_ext);

    // zero seed restarts from the default
    assign w_seed_in = (r_seed == '0) ? DEFAULT_SEED : r_seed;
    assign w_prod    = PROD_W'(w_seed_in) * PROD_W'(LCG_MULT);

    // mod 2^31-1 by folding the high part onto the low part
    assign w_fold = {1'b0, w_prod[SEED_W-1:0]}
                  + (SEED_W+1)'(w_prod[PROD_W-1:SEED_W]);
    assign w_seed_next = (w_fold >= {1'b0, LCG_MODULUS})
                       ? SEED_W'(w_fold - {1'b0, LCG_MODULUS})
                       : w_fold[SEED_W-1:0];

    assign w_step_fire = i_cmd.step && (r_remain != '0);

    always_comb begin
        n_seed     = r_seed;
        n_remain   = r_remain;
        n_count    = r_count;
        n_hit_pend = w_step_fire;
        if (i_seed_wr) begin
            n_seed = i_seed_value;
        end else if (w_step_fire) begin
            n_seed = w_seed_next;
        end
        if (i_cmd.start) begin
            n_remain = w_trials;
            n_count  = '0;
        end else begin
            if (w_step_fire) begin
                n_remain = r_remain - TW'(1);
            end
            // success test runs in the cycle after the step, on the new seed
            if (r_hit_pend && (r_seed <= i_threshold)) begin
                n_count = r_count + TW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed     <= '0;
            r_remain   <= '0;
            r_count    <= '0;
            r_hit_pend <= 1'b0;
        end else begin
            r_seed     <= n_seed;
            r_remain   <= n_remain;
            r_count    <= n_count;
            r_hit_pend <= n_hit_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_success_count <= CNT_W'(r_count);
            o_final_seed    <= r_seed;
        end
    end

    assign o_sts.done = (r_remain == '0);

endmodule

`default_nettype wire

// File: rtl/btc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// btc_ctrl
// draw sequencer: accepts a request word and, when draw_request is set, runs the
// trials and hands the result word to the output register
// ============================================================================
module btc_ctrl
    import btc_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_valid,
    input  wire      i_draw_request,
    output logic     o_ready,
    output logic     o_valid,
    input  wire      i_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_sts  i_sts
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;

    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state        = r_state;
        n_out_valid    = r_out_valid && !i_ready;
        o_cmd.start    = 1'b0;
        o_cmd.step     = 1'b0;
        o_cmd.load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && i_draw_request) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.step = 1'b1;
                if (i_sts.done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_load_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_ready))
        else $error("output word overwritten before it was taken");

    a_request_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_draw_request) |=> (r_state == ST_RUN))
        else $error("accepted draw did not start the trial run");

    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RUN) && i_sts.done) |=> (r_state == ST_FIN))
        else $error("trial run did not finish when counter ran out");

    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == ST_FIN))
        else $error("result word raised outside the finish state");
`endif

endmodule

`default_nettype wire

// File: rtl/binomial_trial_counter.sv
`timescale 1ns / 1ps
`default_nettype none
// a draw of n trials (n = trial_count, capped at MAX_TRIALS) runs from the accepted
//   request word through the run and finish states to the output register
// the single multiply step advances the seed once per cycle in the run state; a new
//   request word is taken only after the result word is loaded and the sequencer is idle
// a request word with draw_request low is taken and gives no word
// reset: synchronous active low; config registers to defaults, running seed to zero
// ============================================================================
// binomial_trial_counter
// binomial variate from the minimal standard generator, seed * 16807 mod
// 2^31-1, counting trials whose new seed is at or below a threshold
// ============================================================================
module binomial_trial_counter
    import btc_pkg::*;
#(
    parameter int unsigned MAX_TRIALS = MAX_TRIALS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // request channel
    input  wire                i_valid,
    output logic               o_ready,
    input  wire                i_draw_request,
    // result channel
    output logic               o_valid,
    input  wire                i_ready,
    output logic [CNT_W-1:0]   o_success_count,
    output logic [SEED_W-1:0]  o_final_seed,
    // register port
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire [ADDR_W-1:0]   paddr,
    input  wire [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    // configuration registers
    logic [CNT_W-1:0]  r_trial_count;
    logic [SEED_W-1:0] r_threshold;
    logic [SEED_W-1:0] r_start_seed;

    logic       w_wr;
    logic [1:0] w_idx;
    logic       w_seed_wr;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // zero wait state port
    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];
    // write lands in the access phase
    assign w_wr      = psel && penable && pwrite && pready;
    assign w_seed_wr = w_wr && (w_idx == REG_START_SEED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trial_count <= '0;
            r_threshold   <= THRESHOLD_RST;
            r_start_seed  <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_TRIAL_COUNT: r_trial_count <= pwdata[CNT_W-1:0];
                REG_THRESHOLD:   r_threshold   <= pwdata[SEED_W-1:0];
                REG_START_SEED:  r_start_seed  <= pwdata[SEED_W-1:0];
                default: begin
                    // unmapped slot, write dropped
                end
            endcase
        end
    end

    // read back mux
    always_comb begin
        case (w_idx)
            REG_TRIAL_COUNT: prdata = DATA_W'(r_trial_count);
            REG_THRESHOLD:   prdata = DATA_W'(r_threshold);
            REG_START_SEED:  prdata = DATA_W'(r_start_seed);
            default:         prdata = '0;
        endcase
    end

    // sequencer
    btc_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_draw_request (i_draw_request),
        .o_ready        (o_ready),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_cmd          (w_cmd),
        .i_sts          (w_sts)
    );

    // generator, counters and result word; seed write reloads the running seed
    btc_datapath #(
        .MAX_TRIALS (MAX_TRIALS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_seed_wr       (w_seed_wr),
        .i_seed_value    (pwdata[SEED_W-1:0]),
        .i_trial_count   (r_trial_count),
        .i_threshold     (r_threshold),
        .o_success_count (o_success_count),
        .o_final_seed    (o_final_seed)
    );

endmodule

`default_nettype wire
